[src/bta_pkg.sv]
// Shared types, codes and tag helpers for the boundary-tag heap allocator.
// Used by boundary_tag_heap_allocator_core; no dependencies.
package bta_pkg;

    // internal byte address width (heap break is below 2^19, sums below 2^20)
    localparam int ADDR_W      = 20;
    localparam int TAG_W       = 32;
    localparam int ALIGN_BYTES = 8;
    localparam int WORD_BYTES  = 4;
    localparam int SIZE_W      = 19;
    localparam int PTR_W       = 18;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 80;
    localparam int WQ_DEPTH    = 4;

    // request kinds
    typedef enum logic [1:0] {
        REQ_MALLOC  = 2'd0,
        REQ_FREE    = 2'd1,
        REQ_REALLOC = 2'd2,
        REQ_INIT    = 2'd3
    } t_req;

    // result status
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NULL = 2'd1,
        ST_OOM  = 2'd2
    } t_status;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_FIT_MODE = 2'd0,
        CFG_CHUNK    = 2'd1,
        CFG_LIMIT    = 2'd2
    } t_cfg_idx;

    // placement policies
    localparam logic [1:0] FIT_NEXT = 2'd1;
    localparam logic [1:0] FIT_BEST = 2'd2;

    // what the block-list walk is looking for
    typedef enum logic {
        WK_ALLOC,
        WK_FIT
    } t_walk;

    // who called coalesce
    typedef enum logic {
        CTX_FREE,
        CTX_EXT
    } t_ctx;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_MAL,
        S_WALK,
        S_WALK_D,
        S_ALLOC_OK,
        S_FREE_R,
        S_FREE_D,
        S_CO_R0,
        S_CO_R1,
        S_CO_R2,
        S_CO_R3,
        S_CO_W,
        S_CO_END,
        S_EXT,
        S_EXT_RET,
        S_PL_R,
        S_PL_D,
        S_PL_END,
        S_RA_R0,
        S_RA_R1,
        S_RA_D,
        S_WQ,
        S_DONE
    } t_state;

    // size | alloc tag word
    function automatic logic [TAG_W-1:0] mk_tag(input logic [ADDR_W-1:0] size,
                                                 input logic alloc);
        mk_tag = {{(TAG_W-ADDR_W){1'b0}}, size[ADDR_W-1:1], alloc};
    endfunction

    // size field of a tag word
    function automatic logic [ADDR_W-1:0] tag_size(input logic [TAG_W-1:0] t);
        tag_size = {t[ADDR_W-1:3], 3'b000};
    endfunction

endpackage

[src/boundary_tag_heap_allocator_core.sv]
// Boundary-tag heap allocator: sequencer over one tag memory.
// Depends on bta_pkg and bta_ram.
// Run time is set mostly by the walks over the implicit block list.
// One request at a time: s_axis_tready is high only while idle.
// Reset (synchronous, i_rst_n low): heap break, base and rover cleared, config
// regs to defaults; tag memory is not cleared and is written by init.
module boundary_tag_heap_allocator_core #(
    parameter int HEAP_WORDS = 65536
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config write port
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_idx,
    input  logic [bta_pkg::SIZE_W-1:0]      i_cfg_data,
    // request channel
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [18:0] req_size, [36:19] block_ptr, [39:37] zero
    input  logic [bta_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]                      s_axis_tuser,
    // result channel
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [17:0] result_ptr, [19:18] status, [20] copy_needed, [38:21] copy_src,
    // [56:39] copy_dst, [75:57] copy_len, [79:76] zero
    output logic [bta_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    import bta_pkg::*;

    localparam int     IW         = $clog2(HEAP_WORDS);
    localparam longint HEAP_BYTES = 4 * longint'(HEAP_WORDS);

    // state and registers
    t_state r_state, n_state;
    t_state r_wret, n_wret;
    t_walk  r_kind, n_kind;
    t_ctx   r_ctx, n_ctx;

    logic [1:0]        r_fit, r_type;
    logic [SIZE_W-1:0] r_chunk, r_limit, r_size, r_clen, n_clen;
    logic [PTR_W-1:0]  r_ptr, r_base, n_base, r_rover, n_rover;
    logic [PTR_W-1:0]  r_res, n_res, r_csrc, n_csrc, r_cdst, n_cdst;
    logic [1:0]        r_status, n_status;
    logic              r_cneed, n_cneed;
    logic [ADDR_W-1:0] r_brk, n_brk, r_bp, n_bp, r_best, n_best, r_bestsz, n_bestsz;
    logic [ADDR_W-1:0] r_start, n_start, r_asize, n_asize, r_csz, n_csz;
    logic [ADDR_W-1:0] r_ptag, n_ptag, r_cs, n_cs, r_ext_bytes, n_ext_bytes;
    logic              r_phase, n_phase, r_grow, n_grow, r_rmove, n_rmove;
    logic              r_ext_fail, n_ext_fail, r_cowr, n_cowr;
    logic [ADDR_W-1:0] r_wa [WQ_DEPTH];
    logic [ADDR_W-1:0] n_wa [WQ_DEPTH];
    logic [TAG_W-1:0]  r_wv [WQ_DEPTH];
    logic [TAG_W-1:0]  n_wv [WQ_DEPTH];
    logic [2:0]        r_wn, n_wn;
    logic [1:0]        r_wi, n_wi;
    logic              r_rd_oor;

    // memory side
    logic [ADDR_W-1:0] rd_addr;
    logic [TAG_W-1:0]  ram_q, rdv;
    logic [IW+ADDR_W-1:0] rd_wide, wr_wide;
    logic              ram_we, rd_oor;
    logic [ADDR_W-1:0] sz, lim, ptr_a;
    logic              walk_end;

    // word index of a byte address, with the out-of-heap check
    assign rd_wide = {{IW{1'b0}}, rd_addr};
    assign wr_wide = {{IW{1'b0}}, r_wa[r_wi]};
    assign rd_oor  = !(longint'(rd_addr[ADDR_W-1:2]) < longint'(HEAP_WORDS));
    assign ram_we  = (r_state == S_WQ) &&
                     (longint'(r_wa[r_wi][ADDR_W-1:2]) < longint'(HEAP_WORDS));
    assign rdv     = r_rd_oor ? '0 : ram_q;
    assign sz      = tag_size(rdv);
    assign ptr_a   = ADDR_W'(r_ptr);

    bta_ram #(
        .WIDTH (TAG_W),
        .DEPTH (HEAP_WORDS)
    ) u_tags (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_wide[IW+1:2]),
        .i_wdata (r_wv[r_wi]),
        .i_raddr (rd_wide[IW+1:2]),
        .o_rdata (ram_q)
    );

    // effective limit: min(heap_limit, heap bytes)
    always_comb begin
        if (longint'(r_limit) < HEAP_BYTES) begin
            lim = ADDR_W'(r_limit);
        end else begin
            lim = ADDR_W'(HEAP_BYTES);
        end
    end

    // handshake and result
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_DONE);
    assign m_axis_tdata  = {4'b0000, r_clen, r_cdst, r_csrc, r_cneed, r_status, r_res};

    // state register and config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_brk   <= '0;
            r_base  <= '0;
            r_rover <= '0;
            r_fit   <= FIT_NEXT;
            r_chunk <= SIZE_W'(4096);
            r_limit <= SIZE_W'(262144);
            r_wn    <= '0;
            r_wi    <= '0;
        end else begin
            r_state <= n_state;
            r_brk   <= n_brk;
            r_base  <= n_base;
            r_rover <= n_rover;
            r_wn    <= n_wn;
            r_wi    <= n_wi;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_FIT_MODE: r_fit   <= i_cfg_data[1:0];
                    CFG_CHUNK:    r_chunk <= i_cfg_data;
                    CFG_LIMIT:    r_limit <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_type <= s_axis_tuser;
            r_size <= s_axis_tdata[18:0];
            r_ptr  <= s_axis_tdata[36:19];
        end
        r_wret      <= n_wret;
        r_kind      <= n_kind;
        r_ctx       <= n_ctx;
        r_res       <= n_res;
        r_status    <= n_status;
        r_cneed     <= n_cneed;
        r_csrc      <= n_csrc;
        r_cdst      <= n_cdst;
        r_clen      <= n_clen;
        r_bp        <= n_bp;
        r_best      <= n_best;
        r_bestsz    <= n_bestsz;
        r_start     <= n_start;
        r_asize     <= n_asize;
        r_csz       <= n_csz;
        r_ptag      <= n_ptag;
        r_cs        <= n_cs;
        r_ext_bytes <= n_ext_bytes;
        r_phase     <= n_phase;
        r_grow      <= n_grow;
        r_rmove     <= n_rmove;
        r_ext_fail  <= n_ext_fail;
        r_cowr      <= n_cowr;
        r_wa        <= n_wa;
        r_wv        <= n_wv;
        r_rd_oor    <= rd_oor;
    end

    // sequencer
    always_comb begin
        logic [ADDR_W-1:0] end_a, nsz, psz, bs, csz2;
        logic [ADDR_W:0]   esize, req8;
        logic [ADDR_W-1:0] w2;
        logic              fits;

        n_state = r_state;  n_wret = r_wret;  n_kind = r_kind;  n_ctx = r_ctx;
        n_brk = r_brk;  n_base = r_base;  n_rover = r_rover;
        n_res = r_res;  n_status = r_status;  n_cneed = r_cneed;
        n_csrc = r_csrc;  n_cdst = r_cdst;  n_clen = r_clen;
        n_bp = r_bp;  n_best = r_best;  n_bestsz = r_bestsz;  n_start = r_start;
        n_asize = r_asize;  n_csz = r_csz;  n_ptag = r_ptag;  n_cs = r_cs;
        n_ext_bytes = r_ext_bytes;  n_phase = r_phase;  n_grow = r_grow;
        n_rmove = r_rmove;  n_ext_fail = r_ext_fail;  n_cowr = r_cowr;
        n_wa = r_wa;  n_wv = r_wv;  n_wn = r_wn;  n_wi = r_wi;
        rd_addr = '0;
        walk_end = 1'b0;
        end_a = '0;  nsz = '0;  psz = '0;  bs = '0;  csz2 = '0;
        esize = '0;  req8 = '0;  w2 = '0;  fits = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_res = '0;  n_status = ST_OK;  n_cneed = 1'b0;
                    n_csrc = '0;  n_cdst = '0;  n_clen = '0;
                    n_grow = 1'b0;  n_rmove = 1'b0;
                    n_state = S_DECODE;
                end
            end

            S_DECODE: begin
                case (t_req'(r_type))
                    REQ_INIT: begin
                        n_brk = '0;  n_base = '0;  n_rover = '0;
                        if (lim < ADDR_W'(16)) begin
                            n_status = ST_OOM;
                            n_state  = S_DONE;
                        end else begin
                            // padding, prologue header/footer, epilogue
                            n_wa[0] = ADDR_W'(0);   n_wv[0] = '0;
                            n_wa[1] = ADDR_W'(4);   n_wv[1] = mk_tag(ADDR_W'(ALIGN_BYTES), 1'b1);
                            n_wa[2] = ADDR_W'(8);   n_wv[2] = mk_tag(ADDR_W'(ALIGN_BYTES), 1'b1);
                            n_wa[3] = ADDR_W'(12);  n_wv[3] = mk_tag('0, 1'b1);
                            n_wn = 3'd4;  n_wi = '0;
                            n_brk = ADDR_W'(16);  n_base = PTR_W'(8);  n_rover = PTR_W'(8);
                            n_ext_bytes = ADDR_W'(r_chunk);
                            n_wret = S_EXT;
                            n_state = S_WQ;
                        end
                    end
                    REQ_MALLOC: n_state = S_MAL;
                    REQ_FREE, REQ_REALLOC: begin
                        if (r_type == REQ_REALLOC && r_ptr == '0) begin
                            n_state = S_MAL;
                        end else if (r_base == '0 || r_ptr == '0) begin
                            n_status = ST_NULL;
                            n_state  = S_DONE;
                        end else begin
                            n_kind = WK_ALLOC;  n_bp = ADDR_W'(r_base);  n_phase = 1'b0;
                            n_state = S_WALK;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end

            S_MAL: begin
                if (r_size == '0) begin
                    n_status = ST_NULL;
                    n_state  = S_DONE;
                end else if (r_base == '0) begin
                    n_status = ST_OOM;
                    n_state  = S_DONE;
                end else begin
                    n_asize = (ADDR_W'(r_size) + ADDR_W'(15)) & ~ADDR_W'(7);
                    // next fit starts at the rover when it lies in the heap
                    if (r_rover < r_base || ADDR_W'(r_rover) >= r_brk) begin
                        n_start = ADDR_W'(r_base);
                    end else begin
                        n_start = ADDR_W'(r_rover);
                    end
                    n_bp = (r_fit == FIT_NEXT) ? n_start : ADDR_W'(r_base);
                    n_kind = WK_FIT;  n_phase = 1'b0;  n_best = '0;  n_bestsz = '0;
                    n_state = S_WALK;
                end
            end

            // walk the implicit list: bound check, then header read
            S_WALK: begin
                if (r_bp < r_brk && (!r_phase || r_bp < r_start)) begin
                    rd_addr = r_bp - ADDR_W'(WORD_BYTES);
                    n_state = S_WALK_D;
                end else begin
                    walk_end = 1'b1;
                end
            end

            S_WALK_D: begin
                if (sz == '0) begin
                    walk_end = 1'b1;
                end else if (r_kind == WK_ALLOC) begin
                    if (r_bp == ptr_a) begin
                        if (r_bp != ADDR_W'(r_base) && rdv[0]) begin
                            n_state = S_ALLOC_OK;
                        end else begin
                            n_status = ST_NULL;
                            n_state  = S_DONE;
                        end
                    end else begin
                        n_bp = r_bp + sz;
                        n_state = S_WALK;
                    end
                end else begin
                    fits = !rdv[0] && (r_asize <= sz);
                    n_bp = r_bp + sz;
                    n_state = S_WALK;
                    if (fits) begin
                        if (r_fit != FIT_BEST) begin
                            n_bp = r_bp;
                            n_state = S_PL_R;
                        end else if (r_best == '0 || sz <= r_bestsz) begin
                            n_best = r_bp;
                            n_bestsz = sz;
                        end
                    end
                end
            end

            S_ALLOC_OK: begin
                if (r_type == REQ_FREE) begin
                    n_state = S_FREE_R;
                end else if (r_size == '0) begin
                    n_status = ST_NULL;
                    n_state  = S_FREE_R;
                end else begin
                    n_state = S_RA_R0;
                end
            end

            // free: clear alloc bit on both tags, then coalesce
            S_FREE_R: begin
                rd_addr = ptr_a - ADDR_W'(WORD_BYTES);
                n_state = S_FREE_D;
            end

            S_FREE_D: begin
                n_wa[0] = ptr_a - ADDR_W'(WORD_BYTES);           n_wv[0] = mk_tag(sz, 1'b0);
                n_wa[1] = ptr_a + sz - ADDR_W'(ALIGN_BYTES);     n_wv[1] = mk_tag(sz, 1'b0);
                n_wn = 3'd2;  n_wi = '0;
                n_bp = ptr_a;  n_ctx = CTX_FREE;
                n_wret = S_CO_R0;
                n_state = S_WQ;
            end

            // coalesce: own header, previous footer, next header
            S_CO_R0: begin
                rd_addr = r_bp - ADDR_W'(WORD_BYTES);
                n_state = S_CO_R1;
            end

            S_CO_R1: begin
                n_csz = sz;
                rd_addr = r_bp - ADDR_W'(ALIGN_BYTES);
                n_state = S_CO_R2;
            end

            S_CO_R2: begin
                n_ptag = rdv[ADDR_W-1:0];
                rd_addr = r_bp + r_csz - ADDR_W'(WORD_BYTES);
                n_state = S_CO_R3;
            end

            S_CO_R3: begin
                psz = r_ptag[0] ? '0 : {r_ptag[ADDR_W-1:3], 3'b000};
                nsz = rdv[0] ? '0 : sz;
                n_csz = r_csz + psz + nsz;
                n_bp = r_bp - psz;
                n_cowr = !(r_ptag[0] && rdv[0]);
                n_state = S_CO_W;
            end

            S_CO_W: begin
                if (r_cowr) begin
                    n_wa[0] = r_bp - ADDR_W'(WORD_BYTES);             n_wv[0] = mk_tag(r_csz, 1'b0);
                    n_wa[1] = r_bp + r_csz - ADDR_W'(ALIGN_BYTES);    n_wv[1] = mk_tag(r_csz, 1'b0);
                    n_wn = 3'd2;  n_wi = '0;
                    n_wret = S_CO_END;
                    n_state = S_WQ;
                end else begin
                    n_state = S_CO_END;
                end
            end

            S_CO_END: begin
                n_rover = r_bp[PTR_W-1:0];
                n_state = (r_ctx == CTX_FREE) ? S_DONE : S_EXT_RET;
            end

            // extend the heap by a free block and a new epilogue
            S_EXT: begin
                w2 = ADDR_W'(r_ext_bytes[ADDR_W-1:2]) + ADDR_W'(r_ext_bytes[2]);
                esize = {w2[ADDR_W-2:0], 2'b00};
                if (esize < (ADDR_W+1)'(ALIGN_BYTES)) begin
                    esize = (ADDR_W+1)'(ALIGN_BYTES);
                end
                if (r_brk > lim || esize > {1'b0, lim - r_brk}) begin
                    n_ext_fail = 1'b1;
                    n_state = S_EXT_RET;
                end else begin
                    end_a = r_brk + esize[ADDR_W-1:0];
                    n_ext_fail = 1'b0;
                    n_bp = r_brk;
                    n_brk = end_a;
                    n_wa[0] = r_brk - ADDR_W'(WORD_BYTES);   n_wv[0] = mk_tag(esize[ADDR_W-1:0], 1'b0);
                    n_wa[1] = end_a - ADDR_W'(ALIGN_BYTES);  n_wv[1] = mk_tag(esize[ADDR_W-1:0], 1'b0);
                    n_wa[2] = end_a - ADDR_W'(WORD_BYTES);   n_wv[2] = mk_tag('0, 1'b1);
                    n_wn = 3'd3;  n_wi = '0;
                    n_ctx = CTX_EXT;
                    n_wret = S_CO_R0;
                    n_state = S_WQ;
                end
            end

            S_EXT_RET: begin
                if (r_type == REQ_INIT) begin
                    n_status = r_ext_fail ? ST_OOM : ST_OK;
                    n_state = S_DONE;
                end else if (r_ext_fail) begin
                    n_status = ST_OOM;
                    n_res = '0;
                    n_state = S_DONE;
                end else begin
                    n_state = S_PL_R;
                end
            end

            // place: split when at least one aligned unit remains
            S_PL_R: begin
                rd_addr = r_bp - ADDR_W'(WORD_BYTES);
                n_state = S_PL_D;
            end

            S_PL_D: begin
                end_a = r_bp + r_asize;
                csz2 = sz - r_asize;
                n_wi = '0;
                n_wret = S_PL_END;
                n_state = S_WQ;
                if ({1'b0, sz} >= {1'b0, r_asize} + (ADDR_W+1)'(ALIGN_BYTES)) begin
                    n_wa[0] = r_bp - ADDR_W'(WORD_BYTES);        n_wv[0] = mk_tag(r_asize, 1'b1);
                    n_wa[1] = end_a - ADDR_W'(ALIGN_BYTES);      n_wv[1] = mk_tag(r_asize, 1'b1);
                    n_wa[2] = end_a - ADDR_W'(WORD_BYTES);       n_wv[2] = mk_tag(csz2, 1'b0);
                    n_wa[3] = r_bp + sz - ADDR_W'(ALIGN_BYTES);  n_wv[3] = mk_tag(csz2, 1'b0);
                    n_wn = 3'd4;
                end else begin
                    n_wa[0] = r_bp - ADDR_W'(WORD_BYTES);        n_wv[0] = mk_tag(sz, 1'b1);
                    n_wa[1] = r_bp + sz - ADDR_W'(ALIGN_BYTES);  n_wv[1] = mk_tag(sz, 1'b1);
                    n_wn = 3'd2;
                end
            end

            S_PL_END: begin
                n_rover = r_bp[PTR_W-1:0];
                n_status = ST_OK;
                if (r_grow) begin
                    n_res = r_ptr;
                    n_state = S_DONE;
                end else begin
                    n_res = r_bp[PTR_W-1:0];
                    if (r_rmove) begin
                        // moved: report copy, then release the old block
                        n_cneed = 1'b1;
                        n_csrc = r_ptr;
                        n_cdst = r_bp[PTR_W-1:0];
                        if (ADDR_W'(r_size) < r_cs - ADDR_W'(ALIGN_BYTES)) begin
                            n_clen = r_size;
                        end else begin
                            n_clen = SIZE_W'(r_cs - ADDR_W'(ALIGN_BYTES));
                        end
                        n_state = S_FREE_R;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end

            // realloc: current size, then next block's header
            S_RA_R0: begin
                rd_addr = ptr_a - ADDR_W'(WORD_BYTES);
                n_state = S_RA_R1;
            end

            S_RA_R1: begin
                n_cs = sz;
                rd_addr = ptr_a + sz - ADDR_W'(WORD_BYTES);
                n_state = S_RA_D;
            end

            S_RA_D: begin
                bs = r_cs + sz;
                req8 = (ADDR_W+1)'(r_size) + (ADDR_W+1)'(ALIGN_BYTES);
                if (req8 <= {1'b0, r_cs}) begin
                    n_res = r_ptr;
                    n_state = S_DONE;
                end else if (!rdv[0] && req8 <= {1'b0, bs}) begin
                    n_wa[0] = ptr_a - ADDR_W'(WORD_BYTES);       n_wv[0] = mk_tag(bs, 1'b1);
                    n_wa[1] = ptr_a + bs - ADDR_W'(ALIGN_BYTES); n_wv[1] = mk_tag(bs, 1'b1);
                    n_wn = 3'd2;  n_wi = '0;
                    n_bp = ptr_a;
                    n_grow = 1'b1;
                    n_asize = (ADDR_W'(r_size) + ADDR_W'(15)) & ~ADDR_W'(7);
                    n_wret = S_PL_R;
                    n_state = S_WQ;
                end else begin
                    n_rmove = 1'b1;
                    n_state = S_MAL;
                end
            end

            // drain queued tag writes, one per cycle
            S_WQ: begin
                n_wi = r_wi + 2'd1;
                if ({1'b0, r_wi} == r_wn - 3'd1) begin
                    n_state = r_wret;
                end
            end

            S_DONE: begin
                if (m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase

        // end of a walk pass
        if (walk_end) begin
            if (r_kind == WK_FIT && r_fit == FIT_NEXT && !r_phase) begin
                n_phase = 1'b1;
                n_bp = ADDR_W'(r_base);
                n_state = S_WALK;
            end else if (r_kind == WK_ALLOC) begin
                n_status = ST_NULL;
                n_state = S_DONE;
            end else if (r_best != '0) begin
                n_bp = r_best;
                n_state = S_PL_R;
            end else begin
                n_ext_bytes = (r_asize > ADDR_W'(r_chunk)) ? r_asize : ADDR_W'(r_chunk);
                n_state = S_EXT;
            end
        end
    end

    // checks
    a_accept_clears_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
        else $error("result shown right after accepting a request");

    a_break_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_brk[2:0] == 3'b000)
        else $error("heap break not 8-byte aligned");

    a_copy_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_cneed) |-> (r_status == ST_OK))
        else $error("copy request with failing status");

    a_wq_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WQ) |-> (r_wn != 3'd0 && {1'b0, r_wi} < r_wn))
        else $error("tag write queue index out of range");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("accepting while a result is pending");

endmodule

[src/bta_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bta_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
